>>> rtl/oale_pkg.sv
// ----------------------------------------------------------------------------
// oale_pkg
// Shared widths, command opcodes and status codes of the ordered array list
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package oale_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 3;
  localparam int unsigned PosW  = 11;
  localparam int unsigned ValW  = 32;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned STdataW = 48;  // position + data_value = 43 bits
  localparam int unsigned MTdataW = 56;  // read_value + found + count = 54 bits

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } opcode_e;

  typedef enum logic [StW-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

endpackage

`default_nettype wire

>>> rtl/oale_ram.sv
// ----------------------------------------------------------------------------
// oale_ram
// Simple dual-port list storage: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oale_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/ordered_array_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top
// Ordered list of up to DEPTH signed 32-bit values kept in one synchronous
// memory, with clear, append, insert, delete, search and read commands.
// ----------------------------------------------------------------------------
// The engine handles one command word at a time and returns exactly one
// result word per command. Clear, append, unused opcodes and every command
// rejected by its checks go from the check state straight to the done
// state; read fetches its one entry through the memory read port. Insert,
// delete and search walk the stored entries through the single memory read
// port, one entry per cycle: insert moves the entries from the top down to
// position p up by one place and then writes the new value, delete moves
// the entries above position p down by one place (none when it removes the
// last entry), and search stops at its first match or at the list end. The
// engine is ready for the next command word once the result is loaded,
// while that result still waits in the output register; a result held by a
// stalled consumer holds the engine in its done state. The memory needs no
// clearing after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list_engine_top #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Command stream
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  // [10:0] position, [42:11] data_value, [47:43] zero
  input  wire logic [oale_pkg::STdataW-1:0] s_axis_tdata,
  // [2:0] opcode
  input  wire logic [oale_pkg::OpW-1:0]     s_axis_tuser,
  // Result stream
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [31:0] read_value, [42:32] found_position, [53:43] entry_count, [55:54] zero
  output      logic [oale_pkg::MTdataW-1:0] m_axis_tdata,
  // [2:0] status
  output      logic [oale_pkg::StW-1:0]     m_axis_tuser
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  // Common width for comparing a position against the count.
  localparam int unsigned CmpW  = (CntW > oale_pkg::PosW) ? CntW : oale_pkg::PosW;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // wait for a command word
    S_EXEC = 6'b000010,  // check the command, start a walk or finish
    S_WALK = 6'b000100,  // issue one memory read per cycle
    S_TAIL = 6'b001000,  // consume the last read of the walk
    S_PUT  = 6'b010000,  // write the inserted value
    S_DONE = 6'b100000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;

  // Command registers
  logic [oale_pkg::OpW-1:0]  cmd_op_q,  cmd_op_d;
  logic [oale_pkg::PosW-1:0] cmd_pos_q, cmd_pos_d;
  logic [oale_pkg::ValW-1:0] cmd_val_q, cmd_val_d;

  // List state
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] end_q, end_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic             rd_pend_q, rd_pend_d;

  // Result being built
  oale_pkg::status_e         res_st_q,   res_st_d;
  logic [oale_pkg::ValW-1:0] res_rval_q, res_rval_d;
  logic [oale_pkg::PosW-1:0] res_fpos_q, res_fpos_d;

  // Output register
  logic                         m_valid_q, m_valid_d;
  logic [oale_pkg::MTdataW-1:0] m_data_q,  m_data_d;
  logic [oale_pkg::StW-1:0]     m_user_q,  m_user_d;

  // Memory port
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic [oale_pkg::ValW-1:0] ram_wdata;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic [oale_pkg::ValW-1:0] ram_rdata;

  // Derived values
  logic [CmpW-1:0]           cnt_ext;
  logic [CmpW-1:0]           pos_ext;
  logic [CmpW-1:0]           fpos_ext;
  logic [CntW-1:0]           cnt_m1;
  logic [AddrW-1:0]          pos_m1;
  logic                      pos_ok;
  logic                      hit;

  assign cnt_ext  = CmpW'(cnt_q);
  assign pos_ext  = CmpW'(cmd_pos_q);
  assign fpos_ext = CmpW'(rd_addr_q) + CmpW'(1);
  assign cnt_m1   = cnt_q - CntW'(1);
  // Only used once the position is known to lie in 1..count.
  assign pos_m1   = AddrW'(pos_ext - CmpW'(1));
  assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign hit      = rd_pend_q && (cmd_op_q == oale_pkg::OP_SEARCH) &&
                    (ram_rdata == cmd_val_q);

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_op_d   = cmd_op_q;
    cmd_pos_d  = cmd_pos_q;
    cmd_val_d  = cmd_val_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    end_d      = end_q;
    rd_addr_d  = rd_addr_q;
    rd_pend_d  = 1'b0;
    res_st_d   = res_st_q;
    res_rval_d = res_rval_q;
    res_fpos_d = res_fpos_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = idx_q;

    // Drop the output word once taken.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // Consume the read issued in the previous cycle: shift the entry by one
    // place, or capture it for read and search.
    if (rd_pend_q) begin
      case (cmd_op_q)
        oale_pkg::OP_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_q + AddrW'(1);
        end
        oale_pkg::OP_DELETE: begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_q - AddrW'(1);
        end
        oale_pkg::OP_READ: begin
          res_rval_d = ram_rdata;
        end
        default: begin
          if (hit) begin
            res_st_d   = oale_pkg::ST_OK;
            res_fpos_d = fpos_ext[oale_pkg::PosW-1:0];
          end
        end
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_op_d  = s_axis_tuser;
          cmd_pos_d = s_axis_tdata[oale_pkg::PosW-1:0];
          cmd_val_d = s_axis_tdata[oale_pkg::PosW +: oale_pkg::ValW];
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        res_st_d   = oale_pkg::ST_OK;
        res_rval_d = '0;
        res_fpos_d = '0;
        state_d    = S_DONE;
        case (cmd_op_q)
          oale_pkg::OP_CLEAR: begin
            cnt_d = '0;
          end
          oale_pkg::OP_APPEND: begin
            if (cnt_q == DepthC) begin
              res_st_d = oale_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[AddrW-1:0];
              ram_wdata = cmd_val_q;
              cnt_d     = cnt_q + CntW'(1);
            end
          end
          oale_pkg::OP_INSERT: begin
            if (cnt_q == '0) begin
              res_st_d = oale_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
              res_st_d = oale_pkg::ST_BADPOS;
            end else if (cnt_q == DepthC) begin
              res_st_d = oale_pkg::ST_FULL;
            end else begin
              // Move entries up, starting from the top one.
              idx_d   = cnt_m1[AddrW-1:0];
              end_d   = pos_m1;
              state_d = S_WALK;
            end
          end
          oale_pkg::OP_DELETE: begin
            if (cnt_q == '0) begin
              res_st_d = oale_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
              res_st_d = oale_pkg::ST_BADPOS;
            end else if (pos_ext == cnt_ext) begin
              // Removing the last entry moves nothing.
              cnt_d = cnt_m1;
            end else begin
              idx_d   = AddrW'(pos_ext);
              end_d   = cnt_m1[AddrW-1:0];
              state_d = S_WALK;
            end
          end
          oale_pkg::OP_SEARCH: begin
            if (cnt_q == '0) begin
              res_st_d = oale_pkg::ST_EMPTY;
            end else begin
              res_st_d = oale_pkg::ST_NOTFOUND;
              idx_d    = '0;
              end_d    = cnt_m1[AddrW-1:0];
              state_d  = S_WALK;
            end
          end
          oale_pkg::OP_READ: begin
            if (cnt_q == '0) begin
              res_st_d = oale_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
              res_st_d = oale_pkg::ST_BADPOS;
            end else begin
              idx_d   = pos_m1;
              end_d   = pos_m1;
              state_d = S_WALK;
            end
          end
          default: begin
            // Unused opcodes leave the list alone.
          end
        endcase
      end

      S_WALK: begin
        if (hit) begin
          // First match ends the search; no further read is issued.
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_addr_d = idx_q;
          if (idx_q == end_q) begin
            state_d = S_TAIL;
          end else if (cmd_op_q == oale_pkg::OP_INSERT) begin
            idx_d = idx_q - AddrW'(1);
          end else begin
            idx_d = idx_q + AddrW'(1);
          end
        end
      end

      S_TAIL: begin
        if (cmd_op_q == oale_pkg::OP_INSERT) begin
          state_d = S_PUT;
        end else begin
          if (cmd_op_q == oale_pkg::OP_DELETE) begin
            cnt_d = cnt_m1;
          end
          state_d = S_DONE;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1;
        ram_wdata = cmd_val_q;
        cnt_d     = cnt_q + CntW'(1);
        state_d   = S_DONE;
      end

      S_DONE: begin
        // Load the output register as soon as it is free.
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {
            (oale_pkg::MTdataW - oale_pkg::ValW - 2 * oale_pkg::PosW)'(0),
            cnt_ext[oale_pkg::PosW-1:0],
            res_fpos_q,
            res_rval_q
          };
          m_user_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cmd_op_q   <= cmd_op_d;
    cmd_pos_q  <= cmd_pos_d;
    cmd_val_q  <= cmd_val_d;
    idx_q      <= idx_d;
    end_q      <= end_d;
    rd_addr_q  <= rd_addr_d;
    res_st_q   <= res_st_d;
    res_rval_q <= res_rval_d;
    res_fpos_q <= res_fpos_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  // Reads and writes of one walk never touch the same entry in one cycle,
  // and only one command is in flight, so no forwarding is needed.
  oale_ram #(
    .Depth (DEPTH),
    .Width (oale_pkg::ValW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("entry count above list depth");

  a_wr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CntW'(ram_waddr) <= cnt_q))
    else $error("memory write beyond the list end");

  a_rd_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q) == S_WALK))
    else $error("pending read without a walk");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_DONE))
    else $error("result word loaded outside the done state");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking stream test of the ordered array list engine: a clocked
// driver feeds command words from a backlog, a clocked monitor checks every
// result word against a cycle-free list mirror, both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import oale_pkg::*;

  localparam int unsigned LIST_DEPTH = 1024;
  localparam int unsigned STALL_LIMIT = 20000;  // cycles with no word moving
  localparam int unsigned DRAIN_CYCLES = 24;

  // Opcodes the engine must ignore.
  localparam logic [OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
  } list_cmd_t;

  typedef struct packed {
    status_e         st;
    logic [ValW-1:0] rval;
    logic [PosW-1:0] fpos;
    logic [PosW-1:0] cnt;
  } list_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [STdataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [MTdataW-1:0]  m_axis_tdata;
  logic [StW-1:0]      m_axis_tuser;

  ordered_array_list_engine_top #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Commands waiting to be driven; the head is the word on the bus.
  list_cmd_t cmd_backlog[$];
  // Results predicted for accepted commands, oldest first.
  list_rsp_t pending_results[$];

  // Mirror of the list contents as the engine should hold them.
  logic [ValW-1:0] list_mirror [LIST_DEPTH];
  int unsigned     mirror_cnt = 0;

  // Entry count as seen by the stimulus builder, one step ahead of the mirror.
  int unsigned plan_cnt = 0;

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned quiet_cnt = 0;

  logic [ValW-1:0] value_pool [8];

  // Apply one command to the mirror and return the result it should produce.
  function automatic list_rsp_t apply_list_cmd(input list_cmd_t c);
    list_rsp_t   r;
    int unsigned p;
    int unsigned i;
    bit          hit;
    r.st   = ST_OK;
    r.rval = '0;
    r.fpos = '0;
    p      = c.pos;
    hit    = 1'b0;
    case (c.op)
      OP_CLEAR: begin
        mirror_cnt = 0;
      end
      OP_APPEND: begin
        if (mirror_cnt >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          list_mirror[mirror_cnt] = c.val;
          mirror_cnt++;
        end
      end
      OP_INSERT: begin
        // Empty beats position, position beats full.
        if (mirror_cnt == 0) begin
          r.st = ST_EMPTY;
        end else if (p < 1 || p > mirror_cnt) begin
          r.st = ST_BADPOS;
        end else if (mirror_cnt >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (i = mirror_cnt; i >= p; i--) list_mirror[i] = list_mirror[i-1];
          list_mirror[p-1] = c.val;
          mirror_cnt++;
        end
      end
      OP_DELETE: begin
        if (mirror_cnt == 0) begin
          r.st = ST_EMPTY;
        end else if (p < 1 || p > mirror_cnt) begin
          r.st = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < mirror_cnt; i++) list_mirror[i] = list_mirror[i+1];
          mirror_cnt--;
        end
      end
      OP_SEARCH: begin
        if (mirror_cnt == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.st = ST_NOTFOUND;
          i = 0;
          while (!hit && i < mirror_cnt) begin
            if (list_mirror[i] == c.val) begin
              hit    = 1'b1;
              r.st   = ST_OK;
              r.fpos = PosW'(i + 1);
            end
            i++;
          end
        end
      end
      OP_READ: begin
        if (mirror_cnt == 0) begin
          r.st = ST_EMPTY;
        end else if (p < 1 || p > mirror_cnt) begin
          r.st = ST_BADPOS;
        end else begin
          r.rval = list_mirror[p-1];
        end
      end
      default: ;
    endcase
    r.cnt = PosW'(mirror_cnt);
    return r;
  endfunction

  // Queue one command and track the entry count it leaves behind.
  task automatic queue_cmd(input logic [OpW-1:0] op, input int unsigned pos,
                           input logic [ValW-1:0] val);
    list_cmd_t c;
    bit        pos_ok;
    c.op   = op;
    c.pos  = PosW'(pos);
    c.val  = val;
    pos_ok = (c.pos >= 1 && c.pos <= plan_cnt);
    cmd_backlog.push_back(c);
    case (op)
      OP_CLEAR:  plan_cnt = 0;
      OP_APPEND: if (plan_cnt < LIST_DEPTH) plan_cnt++;
      OP_INSERT: if (plan_cnt > 0 && pos_ok && plan_cnt < LIST_DEPTH) plan_cnt++;
      OP_DELETE: if (plan_cnt > 0 && pos_ok) plan_cnt--;
      default: ;
    endcase
  endtask

  // Hold the sender until every queued command has produced its result.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Build one random command, mostly well-formed and on a short list.
  task automatic queue_random_cmd();
    int unsigned     roll;
    int unsigned     pos;
    logic [OpW-1:0]  op;
    logic [ValW-1:0] val;
    roll = $urandom_range(99);
    if (roll < 3)       op = OP_CLEAR;
    else if (roll < 5)  op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    else if (roll < 30) op = OP_APPEND;
    else if (roll < 50) op = OP_INSERT;
    else if (roll < 65) op = OP_DELETE;
    else if (roll < 80) op = OP_SEARCH;
    else                op = OP_READ;
    // Keep the list short so walks stay cheap.
    if (plan_cnt >= 40 && (op == OP_APPEND || op == OP_INSERT) && $urandom_range(1))
      op = OP_DELETE;

    roll = $urandom_range(99);
    if (roll < 80 && plan_cnt > 0) pos = $urandom_range(plan_cnt, 1);
    else if (roll < 85)            pos = 0;
    else if (roll < 90)            pos = plan_cnt + 1;
    else                           pos = $urandom_range(2047, 0);

    roll = $urandom_range(99);
    if (roll < 50) begin
      val = value_pool[$urandom_range(7)];
    end else if (roll < 60) begin
      case ($urandom_range(3))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        default: val = 32'hFFFF_FFFF;
      endcase
    end else begin
      val = $urandom;
    end
    queue_cmd(op, pos, val);
  endtask

  // Idle decision shared by both sides; no idling inside the quiet window.
  function automatic bit take_break();
    if (cycle_cnt >= 2000 && cycle_cnt < 3500) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  function automatic void check_field(input string tag, input logic [ValW-1:0] expv,
                                      input logic [ValW-1:0] actv);
    if (expv !== actv) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %h actual %h at cycle %0d",
                 tag, expv, actv, cycle_cnt);
    end
  endfunction

  // Driver: advance to the next command word once the current one is taken.
  always @(posedge clk_i) begin
    list_cmd_t head;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        head = cmd_backlog.pop_front();
        pending_results.push_back(apply_list_cmd(head));
      end
      // Never drop a word that has not been taken.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() != 0 && !take_break()) begin
          head = cmd_backlog[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, head.val, head.pos};
          s_axis_tuser  <= head.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result word %h status %0d at cycle %0d",
                     m_axis_tdata, m_axis_tuser, cycle_cnt);
        end else begin
          want = pending_results.pop_front();
          check_field("status", ValW'(want.st), ValW'(m_axis_tuser));
          check_field("read_value", want.rval, m_axis_tdata[31:0]);
          check_field("found_position", ValW'(want.fpos), ValW'(m_axis_tdata[42:32]));
          check_field("entry_count", ValW'(want.cnt), ValW'(m_axis_tdata[53:43]));
        end
      end
      m_axis_tready <= !take_break();
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    int unsigned     k;
    for (k = 0; k < 8; k++) value_pool[k] = $urandom;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list rejects, position bounds, ends of the list,
    // extreme values, ignored opcodes and clear.
    queue_cmd(OP_SEARCH, 0, 32'h0000_0005);
    queue_cmd(OP_READ, 1, 32'h0);
    queue_cmd(OP_DELETE, 1, 32'h0);
    queue_cmd(OP_INSERT, 1, 32'h1111_1111);
    queue_cmd(OP_APPEND, 0, 32'h8000_0000);
    queue_cmd(OP_APPEND, 2047, 32'h7FFF_FFFF);
    queue_cmd(OP_APPEND, 0, 32'h0000_0000);
    queue_cmd(OP_INSERT, 0, 32'h2222_2222);
    queue_cmd(OP_INSERT, 4, 32'h3333_3333);
    queue_cmd(OP_INSERT, 3, 32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 1, 32'h1234_5678);
    queue_cmd(OP_READ, 0, 32'h0);
    queue_cmd(OP_READ, 2047, 32'h0);
    queue_cmd(OP_READ, 1, 32'h0);
    queue_cmd(OP_READ, 5, 32'h0);
    queue_cmd(OP_SEARCH, 0, 32'h7FFF_FFFF);
    queue_cmd(OP_SEARCH, 0, 32'hDEAD_BEEF);
    queue_cmd(OP_DELETE, 5, 32'h0);
    queue_cmd(OP_DELETE, 1, 32'h0);
    queue_cmd(OP_DELETE, 0, 32'h0);
    queue_cmd(OP_DELETE, 1024, 32'h0);
    queue_cmd(OP_SPARE6, 2047, 32'hFFFF_FFFF);
    queue_cmd(OP_SPARE7, 1, 32'h5A5A_5A5A);
    queue_cmd(OP_CLEAR, 0, 32'h0);
    queue_cmd(OP_READ, 1, 32'h0);
    wait_drained();

    for (k = 0; k < 555; k++) queue_random_cmd();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
